// ===== src/elsm_pkg.sv =====
package elsm_pkg;

	localparam int NUM_TYPES_DEF = 8;
	localparam int TYPE_W = 3;
	localparam int PERIOD_W = 16;
	localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd500;

	localparam logic KIND_LATENCY = 1'b0;
	localparam logic KIND_COUNT = 1'b1;

	typedef struct packed {
		logic [31:0] count;
		logic [63:0] total;
		logic [31:0] max;
	} stat_entry_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_UPDATE,
		ST_SCAN,
		ST_EMIT
	} seq_state_t;

endpackage

// ===== src/event_latency_stats_monitor.sv =====
// Event latency statistics monitor.
// An event request is taken when start is high and busy is low; kind selects a
// latency event (count incremented, latency summed, maximum raised) or a count event
// (add_amount added to the count). The entry for type_index is read from a small
// memory, updated in a shared saturating update unit and written back.
// An event with no report passes the read and update states before the next
// request is taken. When the now_tick taken with the event has reached the next
// report time and an entry is nonzero, the sequencer walks the entries one per
// cycle, stopping in an emit state to read out each nonzero entry. Each record
// is shown for one cycle with report_valid high; the final record of a report
// carries last_record, and busy falls as it is shown. The receiver cannot stall.
// The report period register is written through cfg_valid and cfg_data, and
// cfg_ready is always high; it should only be written while busy is low.
// Reset sets the period to 500 ticks, the next report time to zero and marks all
// entries empty; no clearing pass is needed.
module event_latency_stats_monitor import elsm_pkg::*; #(
	parameter int NUM_TYPES = NUM_TYPES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic                 kind,
	input  logic [TYPE_W-1:0]    type_index,
	input  logic [31:0]          elapsed_time,
	input  logic [15:0]          add_amount,
	input  logic [31:0]          now_tick,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [PERIOD_W-1:0]  cfg_data,
	output logic                 report_valid,
	output logic [TYPE_W-1:0]    report_type,
	output logic [31:0]          report_count,
	output logic [63:0]          report_total_latency,
	output logic [31:0]          report_max_latency,
	output logic                 last_record
);

	localparam int AW = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;
	localparam int CW = $clog2(NUM_TYPES + 1);

	seq_state_t state_q, state_d;

	logic [PERIOD_W-1:0] period_q;
	logic [31:0]         next_tick_q;
	logic [NUM_TYPES-1:0] nz_q;
	logic [CW-1:0]       nz_cnt_q;
	logic [AW-1:0]       ptr_q;

	logic                kind_q;
	logic [TYPE_W-1:0]   idx_q;
	logic [31:0]         elapsed_q;
	logic [15:0]         amount_q;
	logic [31:0]         now_q;

	logic                report_valid_q;
	logic                last_record_q;
	logic [TYPE_W-1:0]   report_type_q;
	stat_entry_t         report_q;

	logic [AW-1:0]       idx_addr;
	logic                in_range;
	logic                old_nz;
	logic                new_nz;
	logic                grow;
	logic [CW-1:0]       nz_cnt_next;
	logic [31:0]         tick_diff;
	logic                due;
	logic                accept;

	logic                mem_we;
	logic [AW-1:0]       mem_raddr;
	stat_entry_t         mem_rdata;
	stat_entry_t         old_entry;
	stat_entry_t         new_entry;

	assign accept = start && (state_q == ST_IDLE);
	assign idx_addr = AW'(idx_q);
	assign in_range = 32'(idx_q) < 32'(NUM_TYPES);
	assign old_nz = nz_q[idx_addr];
	assign old_entry = old_nz ? mem_rdata : '0;
	assign new_nz = (new_entry.count != 32'd0);
	assign grow = in_range && !old_nz && new_nz;
	assign nz_cnt_next = nz_cnt_q + CW'(grow);
	assign tick_diff = now_q - next_tick_q;
	assign due = !tick_diff[31];

	elsm_upd_unit u_upd (
		.kind         (kind_q),
		.elapsed_time (elapsed_q),
		.add_amount   (amount_q),
		.old_entry    (old_entry),
		.new_entry    (new_entry)
	);

	elsm_stat_mem #(
		.NUM_TYPES (NUM_TYPES),
		.AW        (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (idx_addr),
		.wdata (new_entry),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				state_d = ST_UPDATE;
			end
			ST_UPDATE: begin
				if (due && nz_cnt_next != '0) begin
					state_d = ST_SCAN;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_SCAN: begin
				if (nz_q[ptr_q]) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (nz_cnt_q == CW'(1)) begin
					state_d = ST_IDLE;
				end else begin
					state_d = ST_SCAN;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		busy = (state_q != ST_IDLE);
		mem_we = (state_q == ST_UPDATE) && in_range;
		mem_raddr = (state_q == ST_SCAN) ? ptr_q : idx_addr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			period_q <= PERIOD_RESET;
			next_tick_q <= '0;
			nz_q <= '0;
			nz_cnt_q <= '0;
			ptr_q <= '0;
			report_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			report_valid_q <= 1'b0;
			if (cfg_valid) begin
				period_q <= cfg_data;
			end
			case (state_q)
				ST_UPDATE: begin
					if (in_range) begin
						nz_q[idx_addr] <= new_nz;
					end
					nz_cnt_q <= nz_cnt_next;
					if (due) begin
						next_tick_q <= now_q + {16'd0, period_q};
					end
					ptr_q <= '0;
				end
				ST_SCAN: begin
					if (!nz_q[ptr_q]) begin
						ptr_q <= ptr_q + AW'(1);
					end
				end
				ST_EMIT: begin
					nz_q[ptr_q] <= 1'b0;
					nz_cnt_q <= nz_cnt_q - CW'(1);
					ptr_q <= ptr_q + AW'(1);
					report_valid_q <= 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= kind;
			idx_q <= type_index;
			elapsed_q <= elapsed_time;
			amount_q <= add_amount;
			now_q <= now_tick;
		end
		if (state_q == ST_EMIT) begin
			report_q <= mem_rdata;
			report_type_q <= TYPE_W'(ptr_q);
			last_record_q <= (nz_cnt_q == CW'(1));
		end
	end

	assign cfg_ready = 1'b1;
	assign report_valid = report_valid_q;
	assign report_type = report_type_q;
	assign report_count = report_q.count;
	assign report_total_latency = report_q.total;
	assign report_max_latency = report_q.max;
	assign last_record = last_record_q;

endmodule

// ===== src/elsm_stat_mem.sv =====
module elsm_stat_mem import elsm_pkg::*; #(
	parameter int NUM_TYPES = NUM_TYPES_DEF,
	parameter int AW = 3
) (
	input  logic            clk,
	input  logic            we,
	input  logic [AW-1:0]   waddr,
	input  stat_entry_t     wdata,
	input  logic [AW-1:0]   raddr,
	output stat_entry_t     rdata
);

	stat_entry_t mem_q [NUM_TYPES];
	stat_entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== src/elsm_upd_unit.sv =====
module elsm_upd_unit import elsm_pkg::*; (
	input  logic          kind,
	input  logic [31:0]   elapsed_time,
	input  logic [15:0]   add_amount,
	input  stat_entry_t   old_entry,
	output stat_entry_t   new_entry
);

	logic [31:0] inc;
	logic [32:0] count_sum;
	logic [64:0] total_sum;

	always_comb begin
		inc = (kind == KIND_COUNT) ? {16'd0, add_amount} : 32'd1;
		count_sum = {1'b0, old_entry.count} + {1'b0, inc};
		total_sum = {1'b0, old_entry.total} + {33'd0, elapsed_time};
		new_entry = old_entry;
		new_entry.count = count_sum[32] ? '1 : count_sum[31:0];
		if (kind == KIND_LATENCY) begin
			new_entry.total = total_sum[64] ? '1 : total_sum[63:0];
			if (elapsed_time > old_entry.max) begin
				new_entry.max = elapsed_time;
			end
		end
	end

endmodule
